FILE: design/fdsc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register reset values of the fan duty step controller.
// No dependencies; every other design file refers to it by scoped names.
package fdsc_pkg;

   localparam int LEVELS_DEFAULT = 5;

   // Serial multiplier geometry: a 21-bit cube, a 14-bit square or a 7-bit temperature times at most 9 bits
   localparam int MCAND_W  = 21;
   localparam int MPLIER_W = 9;
   localparam int PROD_W   = MCAND_W + MPLIER_W;
   localparam int CNT_W    = $clog2(MPLIER_W + 1);

   localparam int TEMP_W = 7;   // magnitude of a positive temperature
   localparam int SQ_W   = 2 * TEMP_W;
   localparam int CUBE_W = 3 * TEMP_W;
   localparam int A_W    = CUBE_W + 8;   // 255 * t^3
   localparam int DUTY_W = 8;
   localparam int HOLD_W = 4;

   localparam logic [TEMP_W-1:0] FULL_TEMP_RESET   = 7'd55;
   localparam logic [63:0]       DUTY_LEVELS_RESET = 64'h0000_00FF_DCB4_8C66;
   localparam logic [63:0]       HOLD_LEVELS_RESET = 64'h0000_0000_000F_AA50;
   localparam logic [DUTY_W-1:0] DUTY_FULL         = 8'd255;
   localparam logic [MPLIER_W-1:0] SCALE_255       = 9'd255;

   // Register indexes of the write port
   localparam logic [1:0] CSR_FULL_TEMP   = 2'd0;
   localparam logic [1:0] CSR_DUTY_LEVELS = 2'd1;
   localparam logic [1:0] CSR_HOLD_LEVELS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_APPLY
   } fdsc_state_type;

   typedef enum logic [2:0] {
      OP_TT,    // t * t
      OP_TTT,   // t^2 * t
      OP_A,     // t^3 * 255
      OP_FF,    // f * f
      OP_FFF,   // f^2 * f
      OP_LVL    // f^3 * (level + 1)
   } fdsc_op_type;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
   } fdsc_mul_req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_now;
      logic              send_duty;
      logic              went_up;
      logic [HOLD_W-1:0] hold_left;
   } fdsc_result_type;

endpackage

FILE: design/fan_duty_step_controller_unit.sv
`timescale 1ns / 1ps
// Top level of the fan duty step controller: sequencer, config registers, result register.
// Depends on fdsc_pkg, fdsc_mul and fdsc_hold.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   req     | req_valid, req_stall, req_temp_a, req_temp_b | in
//   rsp     | rsp_valid, rsp_stall, rsp_duty_now,          | out
//           | rsp_send_duty, rsp_went_up, rsp_hold_left    |
//   csr     | csr_write_en, csr_index, csr_wdata           | in
//
// One beat at a time. A hotter temperature of zero or below goes from accept straight
// to the final update step. A positive one runs five products (t^2, t^3, 255*t^3, f^2,
// f^3) plus m level tests, m from 1 to LEVELS, one after another through the one
// bit-serial multiplier. The sequencer returns to idle before the next accept.
// Reset is synchronous: duty returns to full speed, hold count to zero, registers
// to their defaults. A stalled result holds in the output register; the next beat
// is taken meanwhile and waits only at the final update step.
module fan_duty_step_controller_unit #(
   parameter int LEVELS = fdsc_pkg::LEVELS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [7:0]       req_temp_a,
   input  logic signed [7:0]       req_temp_b,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_duty_now,
   output logic                    rsp_send_duty,
   output logic                    rsp_went_up,
   output logic [3:0]              rsp_hold_left,
   // configuration write port
   input  logic                    csr_write_en,
   input  logic [1:0]              csr_index,
   input  logic [8*LEVELS-1:0]     csr_wdata
);

   localparam int IDX_W   = $clog2(LEVELS);
   localparam int DLVL_W  = 8 * LEVELS;
   localparam int HLVL_W  = 4 * LEVELS;

   // ---------------------------------------------------------------- config
   logic [fdsc_pkg::TEMP_W-1:0] full_temp_ff;
   logic [DLVL_W-1:0]           duty_levels_ff;
   logic [HLVL_W-1:0]           hold_levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_temp_ff   <= fdsc_pkg::FULL_TEMP_RESET;
         duty_levels_ff <= fdsc_pkg::DUTY_LEVELS_RESET[DLVL_W-1:0];
         hold_levels_ff <= fdsc_pkg::HOLD_LEVELS_RESET[HLVL_W-1:0];
      end else if (csr_write_en) begin
         case (csr_index)
            fdsc_pkg::CSR_FULL_TEMP:   full_temp_ff   <= csr_wdata[fdsc_pkg::TEMP_W-1:0];
            fdsc_pkg::CSR_DUTY_LEVELS: duty_levels_ff <= csr_wdata;
            fdsc_pkg::CSR_HOLD_LEVELS: hold_levels_ff <= csr_wdata[HLVL_W-1:0];
            default: ;   // unmapped index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer state
   fdsc_pkg::fdsc_state_type state_ff, state_in;
   fdsc_pkg::fdsc_op_type    op_ff, op_in;

   logic [fdsc_pkg::TEMP_W-1:0] t_ff, t_in;
   logic [fdsc_pkg::SQ_W-1:0]   sq_ff, sq_in;
   logic [fdsc_pkg::CUBE_W-1:0] cube_ff, cube_in;
   logic [fdsc_pkg::A_W-1:0]    a_ff, a_in;
   logic [fdsc_pkg::CUBE_W-1:0] f3_ff, f3_in;
   logic [IDX_W-1:0]            k_ff, k_in;
   logic                        first_ff, first_in;
   logic [fdsc_pkg::DUTY_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0]            hidx_ff, hidx_in;

   logic                        req_accept;
   logic                        slot_free;
   logic                        positive;
   logic signed [7:0]           t_max;
   logic                        finish;
   logic                        above;
   logic [fdsc_pkg::DUTY_W-1:0] level_k;
   logic [fdsc_pkg::DUTY_W-1:0] level_test;

   fdsc_pkg::fdsc_mul_req_type   mul_req;
   logic                         mul_start;
   logic                         mul_done;
   logic [fdsc_pkg::PROD_W-1:0]  product;

   fdsc_pkg::fdsc_result_type    result;
   logic                         apply;
   logic [fdsc_pkg::HOLD_W-1:0]  hold_load;

   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid || !rsp_stall;
   assign t_max      = (req_temp_a > req_temp_b) ? req_temp_a : req_temp_b;
   assign positive   = !t_max[7] && (t_max != 8'sd0);

   assign level_k    = duty_levels_ff[8*k_ff +: 8];
   assign level_test = first_ff ? '0 : level_k;
   // demand exceeds the level under test: 255*t^3 > (level+1)*f^3
   assign above      = {1'b0, a_ff} > product;
   assign hold_load  = hold_levels_ff[4*hidx_ff +: 4];

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdsc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = positive ? fdsc_pkg::ST_START : fdsc_pkg::ST_APPLY;
            end
         end
         fdsc_pkg::ST_START: state_in = fdsc_pkg::ST_WAIT;
         fdsc_pkg::ST_WAIT: begin
            if (mul_done) begin
               state_in = finish ? fdsc_pkg::ST_APPLY : fdsc_pkg::ST_START;
            end
         end
         fdsc_pkg::ST_APPLY: begin
            if (slot_free) begin
               state_in = fdsc_pkg::ST_IDLE;
            end
         end
         default: state_in = fdsc_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      apply     = 1'b0;
      mul_start = 1'b0;
      case (state_ff)
         fdsc_pkg::ST_IDLE:  req_stall = 1'b0;
         fdsc_pkg::ST_START: mul_start = 1'b1;
         fdsc_pkg::ST_APPLY: apply     = slot_free;
         default: ;
      endcase
   end

   // Operands for the multiplier, by step
   always_comb begin
      mul_req.start  = mul_start;
      mul_req.mcand  = '0;
      mul_req.mplier = '0;
      case (op_ff)
         fdsc_pkg::OP_TT: begin
            mul_req.mcand  = fdsc_pkg::MCAND_W'(t_ff);
            mul_req.mplier = fdsc_pkg::MPLIER_W'(t_ff);
         end
         fdsc_pkg::OP_TTT: begin
            mul_req.mcand  = fdsc_pkg::MCAND_W'(sq_ff);
            mul_req.mplier = fdsc_pkg::MPLIER_W'(t_ff);
         end
         fdsc_pkg::OP_A: begin
            mul_req.mcand  = cube_ff;
            mul_req.mplier = fdsc_pkg::SCALE_255;
         end
         fdsc_pkg::OP_FF: begin
            mul_req.mcand  = fdsc_pkg::MCAND_W'(full_temp_ff);
            mul_req.mplier = fdsc_pkg::MPLIER_W'(full_temp_ff);
         end
         fdsc_pkg::OP_FFF: begin
            mul_req.mcand  = fdsc_pkg::MCAND_W'(sq_ff);
            mul_req.mplier = fdsc_pkg::MPLIER_W'(full_temp_ff);
         end
         fdsc_pkg::OP_LVL: begin
            mul_req.mcand  = f3_ff;
            mul_req.mplier = {1'b0, level_test} + 9'd1;
         end
         default: ;
      endcase
   end

   // Datapath: capture products, walk the level table
   always_comb begin
      op_in     = op_ff;
      t_in      = t_ff;
      sq_in     = sq_ff;
      cube_in   = cube_ff;
      a_in      = a_ff;
      f3_in     = f3_ff;
      k_in      = k_ff;
      first_in  = first_ff;
      target_in = target_ff;
      hidx_in   = hidx_ff;
      finish    = 1'b0;
      if (req_accept) begin
         t_in      = t_max[fdsc_pkg::TEMP_W-1:0];
         op_in     = fdsc_pkg::OP_TT;
         target_in = '0;
         hidx_in   = '0;
      end else if (state_ff == fdsc_pkg::ST_WAIT && mul_done) begin
         case (op_ff)
            fdsc_pkg::OP_TT: begin
               sq_in = product[fdsc_pkg::SQ_W-1:0];
               op_in = fdsc_pkg::OP_TTT;
            end
            fdsc_pkg::OP_TTT: begin
               cube_in = product[fdsc_pkg::CUBE_W-1:0];
               op_in   = fdsc_pkg::OP_A;
            end
            fdsc_pkg::OP_A: begin
               a_in  = product[fdsc_pkg::A_W-1:0];
               op_in = fdsc_pkg::OP_FF;
            end
            fdsc_pkg::OP_FF: begin
               sq_in = product[fdsc_pkg::SQ_W-1:0];
               op_in = fdsc_pkg::OP_FFF;
            end
            fdsc_pkg::OP_FFF: begin
               f3_in    = product[fdsc_pkg::CUBE_W-1:0];
               op_in    = fdsc_pkg::OP_LVL;
               first_in = 1'b1;
               k_in     = '0;
            end
            fdsc_pkg::OP_LVL: begin
               if (first_ff) begin
                  // demand at or below zero: duty 0, first hold entry
                  if (!above) begin
                     target_in = '0;
                     hidx_in   = '0;
                     finish    = 1'b1;
                  end
                  first_in = 1'b0;
               end else if (!above) begin
                  target_in = level_k;
                  hidx_in   = k_ff + 1'b1;
                  finish    = 1'b1;
               end else if (k_ff == IDX_W'(LEVELS - 2)) begin
                  // last level taken whether demand exceeds it or not; hold index clamps
                  target_in = duty_levels_ff[DLVL_W-1 -: 8];
                  hidx_in   = IDX_W'(LEVELS - 1);
                  finish    = 1'b1;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdsc_pkg::ST_IDLE;
         op_ff    <= fdsc_pkg::OP_TT;
         first_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         first_ff <= first_in;
         k_ff     <= k_in;
      end
      t_ff      <= t_in;
      sq_ff     <= sq_in;
      cube_ff   <= cube_in;
      a_ff      <= a_in;
      f3_ff     <= f3_in;
      target_ff <= target_in;
      hidx_ff   <= hidx_in;
   end

   // ---------------------------------------------------------------- units
   fdsc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .product (product)
   );

   fdsc_hold u_hold (
      .clock     (clock),
      .reset     (reset),
      .apply     (apply),
      .target    (target_ff),
      .hold_load (hold_load),
      .result    (result)
   );

   // ---------------------------------------------------------------- result register
   logic                         rsp_valid_ff;
   fdsc_pkg::fdsc_result_type    rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (apply) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duty_now  = rsp_data_ff.duty_now;
   assign rsp_send_duty = rsp_data_ff.send_duty;
   assign rsp_went_up   = rsp_data_ff.went_up;
   assign rsp_hold_left = rsp_data_ff.hold_left;

   // ---------------------------------------------------------------- assertions
   a_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == fdsc_pkg::ST_WAIT)
      else $error("multiplier finished outside the wait step");

   a_up_sends : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_went_up |-> rsp_send_duty && rsp_duty_now != 8'd0)
      else $error("raise reported without a nonzero issued duty");

   a_apply_once : assert property (@(posedge clock) disable iff (reset)
      apply |=> !apply && state_ff == fdsc_pkg::ST_IDLE)
      else $error("state update not followed by return to idle");

endmodule

FILE: design/fdsc_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Depends on fdsc_pkg for widths and the request struct.
module fdsc_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  fdsc_pkg::fdsc_mul_req_type    mul_req,
   output logic                          done,
   output logic [fdsc_pkg::PROD_W-1:0]   product
);

   logic [fdsc_pkg::PROD_W-1:0]   acc_ff, acc_in;
   logic [fdsc_pkg::PROD_W-1:0]   mc_ff, mc_in;
   logic [fdsc_pkg::MPLIER_W-1:0] mp_ff, mp_in;
   logic [fdsc_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                          done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         acc_in = '0;
         mc_in  = fdsc_pkg::PROD_W'(mul_req.mcand);
         mp_in  = mul_req.mplier;
         cnt_in = fdsc_pkg::CNT_W'(fdsc_pkg::MPLIER_W);
      end else if (cnt_ff != '0) begin
         // add the shifted multiplicand for a set bit, advance one bit
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in   = {mc_ff[fdsc_pkg::PROD_W-2:0], 1'b0};
         mp_in   = {1'b0, mp_ff[fdsc_pkg::MPLIER_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == fdsc_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: design/fdsc_hold.sv
`timescale 1ns / 1ps
// Duty and hold-count state with the raise-at-once, lower-after-hold rule.
// Depends on fdsc_pkg for the result struct and reset duty.
module fdsc_hold (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              apply,
   input  logic [fdsc_pkg::DUTY_W-1:0]       target,
   input  logic [fdsc_pkg::HOLD_W-1:0]       hold_load,
   output fdsc_pkg::fdsc_result_type         result
);

   logic [fdsc_pkg::DUTY_W-1:0] duty_ff, duty_in;
   logic [fdsc_pkg::HOLD_W-1:0] hold_ff, hold_in;
   logic [fdsc_pkg::HOLD_W-1:0] hold_mid;
   logic                        send, up;

   always_comb begin
      duty_in  = duty_ff;
      hold_mid = hold_ff;
      send     = 1'b0;
      up       = 1'b0;
      if (target > duty_ff) begin
         duty_in  = target;
         hold_mid = hold_load;
         send     = 1'b1;
         up       = 1'b1;
      end else if (hold_ff == '0 && target < duty_ff) begin
         duty_in = target;
         send    = 1'b1;
      end
      // step down, saturate at zero
      hold_in = (hold_mid != '0) ? hold_mid - 1'b1 : hold_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= fdsc_pkg::DUTY_FULL;
         hold_ff <= '0;
      end else if (apply) begin
         duty_ff <= duty_in;
         hold_ff <= hold_in;
      end
   end

   assign result.duty_now  = duty_in;
   assign result.send_duty = send;
   assign result.went_up   = up;
   assign result.hold_left = hold_in;

endmodule
